>>> hdl/hrl_pkg.sv
// Shared types, constants and character tables of the request line decoder.
package hrl_pkg;

	localparam int MAX_PATH_LEN = 1024;
	localparam int LEN_W        = $clog2(MAX_PATH_LEN + 1);
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;

	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [1:0] {
		MC_GET   = 2'd0,
		MC_HEAD  = 2'd1,
		MC_OTHER = 2'd2,
		MC_BAD   = 2'd3
	} method_class_t;

	typedef struct packed {
		logic [1:0]       n_bytes;
		logic [2:0][7:0]  bytes;
		logic             summ;
		method_class_t    mc;
		logic             slash;
		logic [LEN_W-1:0] len;
		logic             ovf;
	} entry_t;

	function automatic logic [7:0] get_char(input logic [1:0] p);
		case (p)
			2'd0:    get_char = "G";
			2'd1:    get_char = "E";
			2'd2:    get_char = "T";
			default: get_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] head_char(input logic [1:0] p);
		case (p)
			2'd0:    head_char = "H";
			2'd1:    head_char = "E";
			2'd2:    head_char = "A";
			2'd3:    head_char = "D";
			default: head_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] proto_char(input logic [2:0] p);
		case (p)
			3'd0:    proto_char = "H";
			3'd1:    proto_char = "T";
			3'd2:    proto_char = "T";
			3'd3:    proto_char = "P";
			3'd4:    proto_char = "/";
			3'd5:    proto_char = "1";
			3'd6:    proto_char = ".";
			default: proto_char = 8'h00;
		endcase
	endfunction

endpackage

>>> hdl/hrl_if.sv
// Channel interfaces: raw request line characters in, decoded items out.
interface hrl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_line;

	modport source (output valid, output in_byte, output end_of_line, input ready);
	modport sink (input valid, input in_byte, input end_of_line, output ready);
	modport monitor (input valid, input in_byte, input end_of_line, input ready);
endinterface

interface hrl_out_if import hrl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [7:0]       out_byte;
	logic [1:0]       method_class;
	logic             ends_in_slash;
	logic [LEN_W-1:0] decoded_length;
	logic             length_overflow;
	logic             last;

	modport source (output valid, output kind, output out_byte, output method_class,
		output ends_in_slash, output decoded_length, output length_overflow,
		output last, input ready);
	modport sink (input valid, input kind, input out_byte, input method_class,
		input ends_in_slash, input decoded_length, input length_overflow,
		input last, output ready);
	modport monitor (input valid, input kind, input out_byte, input method_class,
		input ends_in_slash, input decoded_length, input length_overflow,
		input last, input ready);
endinterface

>>> hdl/hrl_front.sv
// Front end: tokenises the line, matches method and protocol, decodes the path.
module hrl_front import hrl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	hrl_in_if.sink chars,
	input  logic   full,
	output logic   push,
	output entry_t entry
);

	typedef enum logic [1:0] {
		PH_NONE = 2'd0,
		PH_PCT  = 2'd1,
		PH_DOT  = 2'd2
	} phase_t;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		hex_val = (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
	endfunction

	logic [1:0]       tok_q;
	logic             in_tok_q;
	logic [3:0]       pos_q;
	logic [1:0]       mflags_q;
	logic [1:0]       pflags_q;
	phase_t           ph_q;
	logic             hc_q;
	logic [7:0]       hb_q;
	logic             query_q;
	logic             slash_q;
	logic [LEN_W-1:0] count_q;
	logic             ovf_q;

	logic [7:0]       c;
	logic             accept;
	logic             tok_char;
	logic             tend;
	logic [3:0]       p;
	logic [3:0]       pos_after;
	logic             in_tok_after;
	logic [1:0]       m_c;
	logic [1:0]       pf_c;
	logic             slash_c;

	logic             p0_emit;
	logic [7:0]       p0_byte;
	phase_t           p0_ph;
	logic             p0_q;
	logic [7:0]       dval;
	logic             dec_en;
	logic [1:0]       dec_n;
	logic [7:0]       d0;
	logic [7:0]       d1;
	logic [7:0]       d2;
	phase_t           ph_d;
	logic             hc_d;
	logic [7:0]       hb_d;
	logic             q_d;

	logic [1:0]       m_f;
	logic [1:0]       pf_f;
	logic [1:0]       tok_f;
	logic             in_tok_f;
	logic [3:0]       pos_f;
	phase_t           ph_f;
	logic             hc_f;
	logic [1:0]       fl_n;
	logic [7:0]       f0;
	logic [7:0]       f1;

	logic [7:0]       e0;
	logic [7:0]       e1;
	logic [7:0]       e2;
	logic [2:0]       n_raw;
	logic [1:0]       n_all;
	logic [LEN_W-1:0] room;
	logic             over;
	logic [1:0]       k;
	logic [LEN_W-1:0] count_f;
	logic             ovf_f;
	method_class_t    mc;

	assign c            = chars.in_byte;
	assign chars.ready  = !full;
	assign accept       = chars.valid && !full;
	assign tok_char     = (c != CH_SPACE);
	assign tend         = tok_char ? chars.end_of_line : in_tok_q;
	assign p            = in_tok_q ? pos_q : 4'd0;
	assign pos_after    = !tok_char ? pos_q : ((p == 4'hF) ? p : p + 4'd1);
	assign in_tok_after = tok_char || in_tok_q;

	always_comb begin
		m_c = mflags_q;
		pf_c = pflags_q;
		slash_c = slash_q;
		if (tok_char && tok_q == 2'd0) begin
			if (p >= 4'd3 || get_char(p[1:0]) != c) m_c[0] = 1'b0;
			if (p >= 4'd4 || head_char(p[1:0]) != c) m_c[1] = 1'b0;
		end
		if (tok_char && tok_q == 2'd1) begin
			slash_c = (c == CH_SLASH);
		end
		if (tok_char && tok_q == 2'd2) begin
			if (p < 4'd7) begin
				if (proto_char(p[2:0]) != c) pf_c = 2'b00;
			end else if (p == 4'd7) begin
				if (c != CH_ONE) pf_c[0] = 1'b0;
				if (c != CH_ZERO) pf_c[1] = 1'b0;
			end else begin
				pf_c = 2'b00;
			end
		end
	end

	// plain decode of a byte with no escape pending
	assign p0_emit = !(c == CH_PCT || c == CH_QMARK || c == CH_DOT);
	assign p0_byte = (c == CH_PLUS) ? CH_SPACE : c;
	assign p0_ph   = (c == CH_PCT) ? PH_PCT : ((c == CH_DOT) ? PH_DOT : PH_NONE);
	assign p0_q    = (c == CH_QMARK);
	assign dval    = {hex_val(hb_q), hex_val(c)};
	assign dec_en  = tok_char && tok_q == 2'd1 && !query_q;

	always_comb begin
		dec_n = 2'd0;
		d0 = 8'h00;
		d1 = 8'h00;
		d2 = 8'h00;
		ph_d = ph_q;
		hc_d = hc_q;
		hb_d = hb_q;
		q_d = query_q;
		if (dec_en) begin
			case (ph_q)
				PH_PCT: begin
					if (!hc_q) begin
						if (is_hex(c)) begin
							hb_d = c;
							hc_d = 1'b1;
						end else begin
							d0 = CH_PCT;
							d1 = p0_byte;
							dec_n = 2'd1 + {1'b0, p0_emit};
							ph_d = p0_ph;
							hc_d = 1'b0;
							q_d = query_q | p0_q;
						end
					end else if (is_hex(c)) begin
						hc_d = 1'b0;
						if (dval == CH_DOT) begin
							ph_d = PH_DOT;
						end else begin
							d0 = dval;
							dec_n = 2'd1;
							ph_d = PH_NONE;
						end
					end else begin
						d0 = CH_PCT;
						d1 = hb_q;
						d2 = p0_byte;
						dec_n = 2'd2 + {1'b0, p0_emit};
						ph_d = p0_ph;
						hc_d = 1'b0;
						q_d = query_q | p0_q;
					end
				end
				PH_DOT: begin
					if (!hc_q) begin
						if (c == CH_DOT) begin
							hb_d = c;
							hc_d = 1'b1;
						end else begin
							d0 = CH_DOT;
							d1 = p0_byte;
							dec_n = 2'd1 + {1'b0, p0_emit};
							ph_d = p0_ph;
							q_d = query_q | p0_q;
						end
					end else if (c == CH_SLASH) begin
						ph_d = PH_NONE;
						hc_d = 1'b0;
					end else if (c == CH_DOT) begin
						d0 = CH_DOT;
						dec_n = 2'd1;
					end else begin
						d0 = CH_DOT;
						d1 = CH_DOT;
						d2 = p0_byte;
						dec_n = 2'd2 + {1'b0, p0_emit};
						ph_d = p0_ph;
						hc_d = 1'b0;
						q_d = query_q | p0_q;
					end
				end
				default: begin
					d0 = p0_byte;
					dec_n = {1'b0, p0_emit};
					ph_d = p0_ph;
					hc_d = 1'b0;
					q_d = query_q | p0_q;
				end
			endcase
		end
	end

	always_comb begin
		m_f = m_c;
		pf_f = pf_c;
		tok_f = tok_q;
		ph_f = ph_d;
		hc_f = hc_d;
		fl_n = 2'd0;
		f0 = 8'h00;
		f1 = 8'h00;
		if (tend) begin
			case (tok_q)
				2'd0: begin
					if (pos_after != 4'd3) m_f[0] = 1'b0;
					if (pos_after != 4'd4) m_f[1] = 1'b0;
				end
				2'd1: begin
					case (ph_d)
						PH_PCT: begin
							f0 = CH_PCT;
							f1 = hb_d;
							fl_n = 2'd1 + {1'b0, hc_d};
						end
						PH_DOT: begin
							f0 = CH_DOT;
							f1 = CH_DOT;
							fl_n = 2'd1 + {1'b0, hc_d};
						end
						default: fl_n = 2'd0;
					endcase
					ph_f = PH_NONE;
					hc_f = 1'b0;
				end
				2'd2: begin
					if (pos_after != 4'd8) pf_f = 2'b00;
				end
				default: pf_f = pf_c;
			endcase
			if (tok_q != 2'd3) tok_f = tok_q + 2'd1;
		end
	end

	assign in_tok_f = tend ? 1'b0 : in_tok_after;
	assign pos_f    = tend ? 4'd0 : pos_after;

	assign e0 = (dec_n != 2'd0) ? d0 : f0;
	assign e1 = (dec_n >= 2'd2) ? d1 : ((dec_n == 2'd1) ? f0 : f1);
	assign e2 = (dec_n == 2'd3) ? d2 : ((dec_n == 2'd2) ? f0 : f1);

	assign n_raw   = {1'b0, dec_n} + {1'b0, fl_n};
	assign n_all   = (n_raw > 3'd3) ? 2'd3 : n_raw[1:0];
	assign room    = LEN_W'(MAX_PATH_LEN) - count_q;
	assign over    = {{(LEN_W-2){1'b0}}, n_all} > room;
	assign k       = over ? room[1:0] : n_all;
	assign count_f = count_q + {{(LEN_W-2){1'b0}}, k};
	assign ovf_f   = ovf_q | over;

	always_comb begin
		if (tok_f != 2'd3 || pf_f == 2'b00) begin
			mc = MC_BAD;
		end else if (m_f[0]) begin
			mc = MC_GET;
		end else if (m_f[1]) begin
			mc = MC_HEAD;
		end else begin
			mc = MC_OTHER;
		end
	end

	assign push          = accept && (k != 2'd0 || chars.end_of_line);
	assign entry.n_bytes = k;
	assign entry.bytes   = {e2, e1, e0};
	assign entry.summ    = chars.end_of_line;
	assign entry.mc      = mc;
	assign entry.slash   = slash_c;
	assign entry.len     = count_f;
	assign entry.ovf     = ovf_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 2'd0;
			in_tok_q <= 1'b0;
			pos_q <= 4'd0;
			mflags_q <= 2'b11;
			pflags_q <= 2'b11;
			ph_q <= PH_NONE;
			hc_q <= 1'b0;
			query_q <= 1'b0;
			slash_q <= 1'b0;
			count_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (chars.end_of_line) begin
				tok_q <= 2'd0;
				in_tok_q <= 1'b0;
				pos_q <= 4'd0;
				mflags_q <= 2'b11;
				pflags_q <= 2'b11;
				ph_q <= PH_NONE;
				hc_q <= 1'b0;
				query_q <= 1'b0;
				slash_q <= 1'b0;
				count_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				tok_q <= tok_f;
				in_tok_q <= in_tok_f;
				pos_q <= pos_f;
				mflags_q <= m_f;
				pflags_q <= pf_f;
				ph_q <= ph_f;
				hc_q <= hc_f;
				query_q <= q_d;
				slash_q <= slash_c;
				count_q <= count_f;
				ovf_q <= ovf_f;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hb_q <= hb_d;
		end
	end

endmodule

>>> hdl/hrl_fifo.sv
// Entry queue between the front end and the output sequencer.
module hrl_fifo import hrl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   full,
	output logic   head_valid,
	output entry_t head,
	input  logic   pop
);

	entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full       = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

endmodule

>>> hdl/hrl_back.sv
// Back end: walks each queued entry and presents its items in the output register.
module hrl_back import hrl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  entry_t   head,
	output logic     pop,
	hrl_out_if.source items
);

	logic [1:0]       idx_q;
	logic             valid_q;
	logic             kind_q;
	logic [7:0]       byte_q;
	logic [1:0]       mc_q;
	logic             slash_q;
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             last_q;

	logic             load;
	logic             is_byte;
	logic             last_item;
	logic [2:0]       total;
	logic [7:0]       sel_byte;

	assign total     = {1'b0, head.n_bytes} + {2'b00, head.summ};
	assign load      = head_valid && (!valid_q || items.ready);
	assign is_byte   = (idx_q < head.n_bytes);
	assign last_item = (({1'b0, idx_q} + 3'd1) == total);
	assign pop       = load && last_item;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.bytes[0];
			2'd1:    sel_byte = head.bytes[1];
			2'd2:    sel_byte = head.bytes[2];
			default: sel_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= last_item ? 2'd0 : idx_q + 2'd1;
			end else if (items.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (is_byte) begin
				kind_q <= KIND_BYTE;
				byte_q <= sel_byte;
				mc_q <= MC_GET;
				slash_q <= 1'b0;
				len_q <= '0;
				ovf_q <= 1'b0;
				last_q <= 1'b0;
			end else begin
				kind_q <= KIND_SUMMARY;
				byte_q <= 8'h00;
				mc_q <= head.mc;
				slash_q <= head.slash;
				len_q <= head.len;
				ovf_q <= head.ovf;
				last_q <= 1'b1;
			end
		end
	end

	assign items.valid           = valid_q;
	assign items.kind            = kind_q;
	assign items.out_byte        = byte_q;
	assign items.method_class    = mc_q;
	assign items.ends_in_slash   = slash_q;
	assign items.decoded_length  = len_q;
	assign items.length_overflow = ovf_q;
	assign items.last            = last_q;

endmodule

>>> hdl/http_request_line_url_decoder.sv
// Top level of the request line parser with streaming path decode.
//
//   channel  modport  carries                                            per transfer
//   chars    sink     in_byte, end_of_line                               one raw character
//   items    source   kind, out_byte, method_class, ends_in_slash,       one path byte or
//                     decoded_length, length_overflow, last              one line summary
//
// One character is taken per cycle while the four-entry queue has room.
// A character that yields n items (at most four) holds the output register for each item
// in turn, so the sustained rate is one character per cycle when each yields at most one
// item and items.ready stays high. Items reach the output register through a queue entry.
// arst_n clears the parser, queue pointers and output valid; no clearing pass.
// A stalled items channel fills the queue, after which chars.ready drops.
module http_request_line_url_decoder import hrl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	hrl_in_if.sink    chars,
	hrl_out_if.source items
);

	logic   push;
	logic   full;
	logic   head_valid;
	logic   pop;
	entry_t wr_entry;
	entry_t head;

	hrl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.full   (full),
		.push   (push),
		.entry  (wr_entry)
	);

	hrl_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_entry   (wr_entry),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	hrl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.items      (items)
	);

endmodule

>>> hdl/hrl_checker.sv
// Port-level checks of the request line decoder and their binding.
module hrl_checker import hrl_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             valid,
	input logic             ready,
	input logic             kind,
	input logic [7:0]       out_byte,
	input logic [LEN_W-1:0] decoded_length,
	input logic             length_overflow,
	input logic             last
);

	logic [LEN_W-1:0] bytes_q;
	logic             xfer;

	assign xfer = valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
		end else if (xfer) begin
			if (kind == KIND_SUMMARY) begin
				bytes_q <= '0;
			end else begin
				bytes_q <= bytes_q + LEN_W'(1);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(kind)
			&& $stable(out_byte) && $stable(decoded_length))
		else $error("items payload changed while stalled");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (kind == KIND_SUMMARY) == last)
		else $error("last does not mark the summary");

	a_overflow_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == KIND_SUMMARY && length_overflow
			|-> decoded_length == LEN_W'(MAX_PATH_LEN))
		else $error("overflow reported below the length limit");

	a_len_count: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && kind == KIND_SUMMARY |-> decoded_length == bytes_q)
		else $error("summary length differs from path bytes transferred");

endmodule

bind http_request_line_url_decoder hrl_checker u_hrl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.valid           (items.valid),
	.ready           (items.ready),
	.kind            (items.kind),
	.out_byte        (items.out_byte),
	.decoded_length  (items.decoded_length),
	.length_overflow (items.length_overflow),
	.last            (items.last)
);

>>> tb/sv/hrl_line_check.sv
// Channel monitor for the request line decoder: predicts the decoded items and compares them.
module hrl_line_check import hrl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	hrl_in_if.monitor  chars,
	hrl_out_if.monitor items,
	output int         fails,
	output int         awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS_PER_CHAR = 4;
	localparam int MAX_REPORTS    = 100;
	localparam logic [23:0] GET_TEXT   = "GET";
	localparam logic [31:0] HEAD_TEXT  = "HEAD";
	localparam logic [55:0] PROTO_TEXT = "HTTP/1.";

	typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_DOT} esc_t;

	typedef struct {
		logic             kind;
		logic [7:0]       octet;
		method_class_t    mclass;
		logic             slash;
		logic [LEN_W-1:0] len;
		logic             ovf;
		logic             last;
	} item_t;

	item_t      awaited_items[$];
	int         fail_count = 0;
	int         awaited_count = 0;
	int         char_items;
	int         token_idx;
	logic       in_token;
	int         char_pos;
	logic [1:0] method_flags;
	logic [1:0] proto_flags;
	esc_t       esc;
	logic [7:0] held;
	logic       held_valid;
	logic       query;
	logic       slash_last;
	int         path_len;
	logic       path_ovf;

	assign fails   = fail_count;
	assign awaited = awaited_count;

	function automatic void clear_line();
		token_idx    = 0;
		in_token     = 1'b0;
		char_pos     = 0;
		method_flags = 2'b11;
		proto_flags  = 2'b11;
		esc          = ESC_NONE;
		held         = 8'h00;
		held_valid   = 1'b0;
		query        = 1'b0;
		slash_last   = 1'b0;
		path_len     = 0;
		path_ovf     = 1'b0;
	endfunction

	function automatic void push_item(input logic k, input logic [7:0] b,
			input method_class_t mc, input logic sl, input logic [LEN_W-1:0] len,
			input logic ov, input logic la);
		item_t it;
		it.kind   = k;
		it.octet  = b;
		it.mclass = mc;
		it.slash  = sl;
		it.len    = len;
		it.ovf    = ov;
		it.last   = la;
		if (char_items < ITEMS_PER_CHAR) begin
			awaited_items.push_back(it);
			char_items++;
		end
	endfunction

	function automatic void emit_decoded(input logic [7:0] b);
		if (path_len < MAX_PATH_LEN) begin
			push_item(KIND_BYTE, b, MC_GET, 1'b0, '0, 1'b0, 1'b0);
			path_len++;
		end else begin
			path_ovf = 1'b1;
		end
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		if (c >= "0" && c <= "9")
			v = c - "0";
		else if (c >= "a" && c <= "f")
			v = c - "a" + 8'd10;
		else
			v = c - "A" + 8'd10;
		return v[3:0];
	endfunction

	// A failed look-ahead is examined again as a fresh character.
	function automatic void decode_path_char(input logic [7:0] c);
		logic       done;
		logic [7:0] d;
		done = 1'b0;
		for (int pass = 0; pass < 4 && !done; pass++) begin
			case (esc)
				ESC_PCT: begin
					if (!held_valid) begin
						if (is_hex(c)) begin
							held       = c;
							held_valid = 1'b1;
							done       = 1'b1;
						end else begin
							emit_decoded(CH_PCT);
							esc = ESC_NONE;
						end
					end else if (is_hex(c)) begin
						d          = {hex_nibble(held), hex_nibble(c)};
						held_valid = 1'b0;
						if (d == CH_DOT) begin
							esc = ESC_DOT;
						end else begin
							esc = ESC_NONE;
							emit_decoded(d);
						end
						done = 1'b1;
					end else begin
						emit_decoded(CH_PCT);
						emit_decoded(held);
						esc        = ESC_NONE;
						held_valid = 1'b0;
					end
				end
				ESC_DOT: begin
					if (!held_valid) begin
						if (c == CH_DOT) begin
							held       = c;
							held_valid = 1'b1;
							done       = 1'b1;
						end else begin
							emit_decoded(CH_DOT);
							esc = ESC_NONE;
						end
					end else if (c == CH_SLASH) begin
						esc        = ESC_NONE;
						held_valid = 1'b0;
						done       = 1'b1;
					end else begin
						emit_decoded(CH_DOT);
						held_valid = 1'b0;
					end
				end
				default: begin
					esc        = ESC_NONE;
					held_valid = 1'b0;
					if (c == CH_PLUS)
						emit_decoded(CH_SPACE);
					else if (c == CH_PCT)
						esc = ESC_PCT;
					else if (c == CH_QMARK)
						query = 1'b1;
					else if (c == CH_DOT)
						esc = ESC_DOT;
					else
						emit_decoded(c);
					done = 1'b1;
				end
			endcase
		end
	endfunction

	function automatic void flush_path();
		if (esc == ESC_PCT) begin
			emit_decoded(CH_PCT);
			if (held_valid)
				emit_decoded(held);
		end else if (esc == ESC_DOT) begin
			emit_decoded(CH_DOT);
			if (held_valid)
				emit_decoded(CH_DOT);
		end
		esc        = ESC_NONE;
		held_valid = 1'b0;
	endfunction

	function automatic void token_char(input logic [7:0] c);
		case (token_idx)
			0: begin
				if (char_pos >= 3 || GET_TEXT[23 - 8 * char_pos -: 8] != c)
					method_flags[0] = 1'b0;
				if (char_pos >= 4 || HEAD_TEXT[31 - 8 * char_pos -: 8] != c)
					method_flags[1] = 1'b0;
			end
			1: begin
				slash_last = (c == CH_SLASH);
				if (!query)
					decode_path_char(c);
			end
			2: begin
				if (char_pos < 7) begin
					if (PROTO_TEXT[55 - 8 * char_pos -: 8] != c)
						proto_flags = 2'b00;
				end else if (char_pos == 7) begin
					if (c != CH_ONE)
						proto_flags[0] = 1'b0;
					if (c != CH_ZERO)
						proto_flags[1] = 1'b0;
				end else begin
					proto_flags = 2'b00;
				end
			end
			default: ;
		endcase
		if (char_pos < 15)
			char_pos++;
	endfunction

	function automatic void token_end();
		case (token_idx)
			0: begin
				if (char_pos != 3)
					method_flags[0] = 1'b0;
				if (char_pos != 4)
					method_flags[1] = 1'b0;
			end
			1: flush_path();
			2: begin
				if (char_pos != 8)
					proto_flags = 2'b00;
			end
			default: ;
		endcase
		if (token_idx < 3)
			token_idx++;
		in_token = 1'b0;
		char_pos = 0;
	endfunction

	function automatic void parse_char(input logic [7:0] c, input logic eol);
		method_class_t mc;
		char_items = 0;
		if (c == CH_SPACE) begin
			if (in_token)
				token_end();
		end else begin
			if (!in_token) begin
				in_token = 1'b1;
				char_pos = 0;
			end
			token_char(c);
		end
		if (eol) begin
			if (in_token)
				token_end();
			if (token_idx < 3 || proto_flags == 2'b00)
				mc = MC_BAD;
			else if (method_flags[0])
				mc = MC_GET;
			else if (method_flags[1])
				mc = MC_HEAD;
			else
				mc = MC_OTHER;
			push_item(KIND_SUMMARY, 8'h00, mc, slash_last, LEN_W'(path_len), path_ovf, 1'b1);
			clear_line();
		end
	endfunction

	initial clear_line();

	always @(posedge clk) begin
		item_t w;
		if (arst_n) begin
			if (items.valid && items.ready) begin
				if (awaited_items.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: unexpected item, expected none, actual kind %0b byte %h class %0d slash %0b len %0d ovf %0b last %0b",
							$time, items.kind, items.out_byte, items.method_class,
							items.ends_in_slash, items.decoded_length, items.length_overflow,
							items.last);
				end else begin
					w = awaited_items.pop_front();
					if (items.kind !== w.kind || items.out_byte !== w.octet ||
							items.method_class !== w.mclass ||
							items.ends_in_slash !== w.slash ||
							items.decoded_length !== w.len ||
							items.length_overflow !== w.ovf || items.last !== w.last) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("%0t: item mismatch, expected kind %0b byte %h class %0d slash %0b len %0d ovf %0b last %0b",
								$time, w.kind, w.octet, w.mclass, w.slash, w.len, w.ovf,
								w.last);
							$display("%0t: item mismatch, actual kind %0b byte %h class %0d slash %0b len %0d ovf %0b last %0b",
								$time, items.kind, items.out_byte, items.method_class,
								items.ends_in_slash, items.decoded_length,
								items.length_overflow, items.last);
						end
					end
				end
			end
			if (chars.valid && chars.ready)
				parse_char(chars.in_byte, chars.end_of_line);
			awaited_count = awaited_items.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
// Bench top for the request line decoder: clock, reset, character stimulus, watchdog, verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hrl_pkg::*;

	localparam int RESET_CYCLES   = 6;
	localparam int RANDOM_CHARS   = 180;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 400;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	int         fails;
	int         awaited;
	int         idle_cycles = 0;
	logic [7:0] line_q[$];

	hrl_in_if  chars_if ();
	hrl_out_if items_if ();

	http_request_line_url_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.items  (items_if)
	);

	hrl_line_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.items   (items_if),
		.fails   (fails),
		.awaited (awaited)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (chars_if.valid && chars_if.ready) || (items_if.valid && items_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void add_char(input logic [7:0] c);
		line_q.push_back(c);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endfunction

	function automatic void add_spaces(input int n);
		repeat (n) add_char(CH_SPACE);
	endfunction

	function automatic logic [7:0] any_nonspace();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == CH_SPACE)
			c = 8'h21;
		return c;
	endfunction

	function automatic logic [7:0] lower_letter();
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10)
			return 8'h30 + 8'(r);
		else if (r < 16)
			return 8'h61 + 8'(r - 10);
		else
			return 8'h41 + 8'(r - 16);
	endfunction

	function automatic void add_token(input int n);
		repeat (n) add_char(any_nonspace());
	endfunction

	function automatic void add_method();
		case ($urandom_range(0, 9))
			0, 1, 2: add_text("GET");
			3, 4:    add_text("HEAD");
			5:       add_text("POST");
			6:       add_text("GE");
			7:       add_text("HEADS");
			default: add_token($urandom_range(1, 18));
		endcase
	endfunction

	function automatic void add_proto();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: add_text("HTTP/1.1");
			4, 5:       add_text("HTTP/1.0");
			6: begin
				add_text("HTTP/1.");
				add_char(any_nonspace());
			end
			7:          add_text("HTTP/1.1x");
			8:          add_text("HTTP/1.");
			default:    add_token($urandom_range(1, 18));
		endcase
	endfunction

	function automatic void add_path_piece();
		case ($urandom_range(0, 15))
			0, 1: add_char(CH_SLASH);
			2:    add_text("../");
			3: begin
				if ($urandom_range(0, 1) != 0)
					add_text("%2e./");
				else
					add_text("%2E.");
			end
			4:    add_char(CH_DOT);
			5: begin
				add_char(CH_PCT);
				add_char(hex_char());
				add_char(hex_char());
			end
			6: begin
				add_char(CH_PCT);
				add_char(hex_char());
			end
			7:    add_char(CH_PCT);
			8:    add_char(CH_PLUS);
			9:    add_char($urandom_range(0, 2) == 0 ? CH_QMARK : lower_letter());
			10, 11: add_char(any_nonspace());
			default: add_char(lower_letter());
		endcase
	endfunction

	function automatic void gen_request(input bit complete);
		int stop_at;
		if ($urandom_range(0, 5) == 0)
			add_spaces(1);
		add_method();
		stop_at = complete ? 3 : $urandom_range(1, 2);
		if (stop_at > 1) begin
			add_spaces($urandom_range(1, 3));
			if ($urandom_range(0, 4) != 0)
				add_char(CH_SLASH);
			repeat ($urandom_range(0, 8)) add_path_piece();
			if (stop_at > 2) begin
				add_spaces($urandom_range(1, 3));
				add_proto();
				if ($urandom_range(0, 5) == 0) begin
					add_spaces(1);
					add_token($urandom_range(1, 4));
				end
			end
		end
		if ($urandom_range(0, 4) == 0)
			add_spaces($urandom_range(1, 2));
	endfunction

	function automatic void gen_noise();
		repeat ($urandom_range(1, 10))
			add_char($urandom_range(0, 3) == 0 ? CH_SPACE : 8'($urandom_range(0, 255)));
	endfunction

	task automatic send_line(input bit calm);
		int gap;
		for (int i = 0; i < line_q.size(); i++) begin
			gap = calm ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				chars_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			chars_if.valid       <= 1'b1;
			chars_if.in_byte     <= line_q[i];
			chars_if.end_of_line <= (i == line_q.size() - 1);
			@(posedge clk);
			while (!chars_if.ready) @(posedge clk);
			@(negedge clk);
		end
		line_q.delete();
	endtask

	initial begin : sink
		int stall;
		bit calm;
		calm = 1'b0;
		items_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				calm = !calm;
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				items_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			items_if.ready <= 1'b1;
			@(posedge clk);
			while (!items_if.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int sent;
		int pick;
		sent = 0;
		chars_if.valid = 1'b0;
		chars_if.in_byte = 8'h00;
		chars_if.end_of_line = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_text("GET /%41+%g/ HTTP/1.1");
		send_line(1'b0);
		add_text("HEAD /%2e./.?x HTTP/1.0");
		send_line(1'b0);
		add_text("P /%4 HTTP/1.0 z");
		send_line(1'b1);
		add_char(8'hFF);
		send_line(1'b0);
		add_char(8'h00);
		add_text(" /..");
		send_line(1'b0);

		while (sent < RANDOM_CHARS) begin
			pick = $urandom_range(0, 19);
			if (pick < 15)
				gen_request(1'b1);
			else if (pick < 18)
				gen_request(1'b0);
			else
				gen_noise();
			sent += line_q.size();
			send_line($urandom_range(0, 3) == 0);
		end
		chars_if.valid <= 1'b0;

		while (awaited != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
hdl/hrl_pkg.sv
hdl/hrl_if.sv
hdl/hrl_front.sv
hdl/hrl_fifo.sv
hdl/hrl_back.sv
hdl/http_request_line_url_decoder.sv
hdl/hrl_checker.sv
tb/sv/hrl_line_check.sv
tb/sv/tb_top.sv
